>>> rtl/bsi_pkg.sv
// bitmap set package: field widths, operation codes, controller states
// no dependencies; used by the interfaces, the word store and the top level
package bsi_pkg;

  localparam int SET_SIZE_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int OP_W   = 2;
  localparam int ELEM_W = 12;
  localparam int MAXV_W = 10;
  localparam int CNT_W  = 11;
  // scan position (cursor plus one), reaches max_value plus two
  localparam int POS_W  = 11;
  // shift of the reciprocal used to split a position into word and bit
  localparam int DIV_SH = 18;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TEST   = 2'd2,
    OP_NEXT   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_RMW,
    S_SCAN
  } state_e;

endpackage

>>> rtl/bsi_ifs.sv
// valid/ready channels of the bitmap set: operation in, result out, config write
// depends on bsi_pkg
interface bsi_op_if;
  import bsi_pkg::*;
  logic                     valid;
  logic                     ready;
  op_e                      operation;
  logic signed [ELEM_W-1:0] element;
  modport source (output valid, operation, element, input ready);
  modport sink   (input valid, operation, element, output ready);
endinterface

interface bsi_res_if;
  import bsi_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [MAXV_W-1:0] next_value;
  logic [CNT_W-1:0]  member_count;
  logic              error_flag;
  modport source (output valid, ok, next_value, member_count, error_flag, input ready);
  modport sink   (input valid, ok, next_value, member_count, error_flag, output ready);
endinterface

interface bsi_cfg_if;
  import bsi_pkg::*;
  logic              valid;
  logic              ready;
  logic [MAXV_W-1:0] max_value;
  modport source (output valid, max_value, input ready);
  modport sink   (input valid, max_value, output ready);
endinterface

>>> rtl/bsi_word_mem.sv
// bitmap word store: one write and one registered read port, zero sweep after reset
// depends on bsi_pkg for nothing but house conventions
module bsi_word_mem #(
  parameter int WORD_BITS  = 32,
  parameter int WORD_COUNT = 32,
  parameter int AW         = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i,
  output logic                 busy_o
);
  import bsi_pkg::*;

  logic [WORD_BITS-1:0] mem_q [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 clr_busy_q, clr_busy_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == AW'(WORD_COUNT - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_busy_q;

endmodule

>>> rtl/bitmap_set_with_iterator.sv
// bitmap set top level: controller, position split, scan and result register
// depends on bsi_pkg, bsi_ifs and bsi_word_mem
//
// Holds a set of integers 0..max_value as one bit per element in a word memory.
// op_i carries one operation per beat: insert, remove, test, or next (advance a
// cursor to the next member). res_o returns exactly one result beat per operation
// with ok, next_value, member_count and the sticky error_flag. cfg_i writes
// max_value; it is always ready, and the user must see that max_value is
// written only while the block is idle: the block itself does not enforce
// this. Insert, remove and test do one memory read, then write back and
// result load; next reads the word at the scan position and then each
// further word in turn, up to SET_SIZE/WORD_BITS words, one read per word.
// One operation is processed at a time; a new one is taken once the previous
// result sits in the output register, even if the receiver has not taken it.
// When res_o stalls, a finished operation waits in its last step until the
// output register frees up. After reset the block sweeps the memory to zero,
// one word a cycle, with op_i.ready low; the cursor starts before 0 and only
// reset rewinds it.
module bitmap_set_with_iterator #(
  parameter int SET_SIZE  = bsi_pkg::SET_SIZE_DEF,
  parameter int WORD_BITS = bsi_pkg::WORD_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bsi_op_if.sink    op_i,
  bsi_res_if.source res_o,
  bsi_cfg_if.sink   cfg_i
);
  import bsi_pkg::*;

  localparam int WORD_COUNT = (SET_SIZE + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BW         = $clog2(WORD_BITS);
  localparam int RECIP      = ((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W     = POS_W + DIV_SH;
  localparam int TOP_IDX    = SET_SIZE - 1;

  state_e state_q, state_d;

  // operation registers
  op_e                      op_q;
  logic signed [ELEM_W-1:0] elem_q;
  logic [POS_W-1:0]         dvd_q;
  logic [PROD_W-1:0]        prod_q;
  logic [AW-1:0]            addr_q;
  logic [BW-1:0]            bit_q;
  logic [POS_W-1:0]         base_q;
  logic                     go_q;

  // architectural state
  logic [MAXV_W-1:0] max_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              err_q, err_d;
  logic [POS_W-1:0]  pos_q, pos_d;

  // result register
  logic              res_vld_q;
  logic              res_ok_q;
  logic [MAXV_W-1:0] res_val_q;

  // memory port
  logic                 rd_en, wr_en, mem_busy;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_word, wr_data;

  logic                 in_acc, out_free, load, ld_ok, adv;
  logic [MAXV_W-1:0]    ld_val;
  logic [POS_W-1:0]     lim_w, dvd_w, quot_w, base_w, off_w, nbase_w, found_w;
  logic [BW-1:0]        rem_w, hit_idx;
  logic                 go_w, present, hit, last_word;
  logic [WORD_BITS-1:0] bit_mask, lo_mask, hi_mask, cand;

  assign in_acc   = op_i.valid && op_i.ready;
  assign out_free = !res_vld_q || res_o.ready;

  // highest index a scan or an element may touch
  assign lim_w = (int'(max_q) > TOP_IDX) ? POS_W'(TOP_IDX) : POS_W'(max_q);

  assign dvd_w = (op_i.operation == OP_NEXT) ? pos_q : POS_W'(op_i.element);

  // exact quotient by reciprocal for every dividend below 2**POS_W
  assign quot_w = prod_q[DIV_SH +: POS_W];
  assign base_w = POS_W'(quot_w * POS_W'(WORD_BITS));
  assign rem_w  = BW'(dvd_q - base_w);
  assign go_w   = (op_q == OP_NEXT) ? (pos_q <= lim_w)
                                    : (!elem_q[ELEM_W-1] && (POS_W'(elem_q) <= lim_w));

  assign bit_mask = WORD_BITS'(1) << bit_q;
  assign present  = rd_word[bit_q];

  // candidate bits of the current word from the scan position up to the limit
  assign off_w   = lim_w - base_q;
  assign lo_mask = {WORD_BITS{1'b1}} << bit_q;
  assign hi_mask = (off_w >= POS_W'(WORD_BITS - 1)) ? {WORD_BITS{1'b1}}
                 : ({WORD_BITS{1'b1}} >> (POS_W'(WORD_BITS - 1) - off_w));
  assign cand    = rd_word & lo_mask & hi_mask;
  assign hit     = |cand;

  always_comb begin
    hit_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_idx = BW'(j);
      end
    end
  end

  assign found_w   = base_q + POS_W'(hit_idx);
  assign nbase_w   = base_q + POS_W'(WORD_BITS);
  assign last_word = nbase_w > lim_w;

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = addr_q;
    wr_en   = 1'b0;
    wr_data = rd_word;
    load    = 1'b0;
    ld_ok   = 1'b0;
    ld_val  = '0;
    cnt_d   = cnt_q;
    err_d   = err_q;
    pos_d   = pos_q;
    adv     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        if (!mem_busy) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (op_i.valid) state_d = S_ADDR;
      end
      S_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = AW'(quot_w);
        state_d = (op_q == OP_NEXT) ? S_SCAN : S_RMW;
      end
      S_RMW: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
          if (!go_q) begin
            err_d = 1'b1;
          end else begin
            case (op_q)
              OP_INSERT: begin
                ld_ok = 1'b1;
                if (!present) begin
                  wr_en   = 1'b1;
                  wr_data = rd_word | bit_mask;
                  cnt_d   = cnt_q + CNT_W'(1);
                end
              end
              OP_REMOVE: begin
                ld_ok = 1'b1;
                if (present) begin
                  wr_en   = 1'b1;
                  wr_data = rd_word & ~bit_mask;
                  cnt_d   = cnt_q - CNT_W'(1);
                end
              end
              OP_TEST: ld_ok = present;
              default: ld_ok = 1'b0;
            endcase
          end
        end
      end
      S_SCAN: begin
        if (go_q && hit) begin
          if (out_free) begin
            load    = 1'b1;
            ld_ok   = 1'b1;
            ld_val  = MAXV_W'(found_w);
            pos_d   = found_w + POS_W'(1);
            state_d = S_IDLE;
          end
        end else if (go_q && !last_word) begin
          rd_en   = 1'b1;
          rd_addr = addr_q + AW'(1);
          adv     = 1'b1;
        end else if (out_free) begin
          // not found: park the scan position past max_value unless it already lies past it
          load    = 1'b1;
          state_d = S_IDLE;
          if (pos_q <= POS_W'(max_q)) pos_d = POS_W'(max_q) + POS_W'(2);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      max_q     <= '1;
      cnt_q     <= '0;
      err_q     <= 1'b0;
      pos_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      pos_q   <= pos_d;
      if (cfg_i.valid) max_q <= cfg_i.max_value;
      if (load) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_i.operation;
      elem_q <= op_i.element;
      dvd_q  <= dvd_w;
      prod_q <= PROD_W'(dvd_w) * PROD_W'(RECIP);
    end
    if (state_q == S_ADDR) begin
      addr_q <= AW'(quot_w);
      bit_q  <= rem_w;
      base_q <= base_w;
      go_q   <= go_w;
    end else if (adv) begin
      addr_q <= addr_q + AW'(1);
      bit_q  <= '0;
      base_q <= nbase_w;
    end
    if (load) begin
      res_ok_q  <= ld_ok;
      res_val_q <= ld_val;
    end
  end

  bsi_word_mem #(
    .WORD_BITS (WORD_BITS),
    .WORD_COUNT(WORD_COUNT),
    .AW        (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_word),
    .wr_en_i  (wr_en),
    .wr_addr_i(addr_q),
    .wr_data_i(wr_data),
    .busy_o   (mem_busy)
  );

  assign op_i.ready         = (state_q == S_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign res_o.valid        = res_vld_q;
  assign res_o.ok           = res_ok_q;
  assign res_o.next_value   = res_val_q;
  // count and error only change when a result loads, so they track the latest beat
  assign res_o.member_count = cnt_q;
  assign res_o.error_flag   = err_q;

endmodule

>>> rtl/bsi_chk.sv
// port-level checker for the bitmap set, bound to the top level
// depends on bsi_pkg and the top level bitmap_set_with_iterator
module bsi_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      ok_i,
  input logic [bsi_pkg::MAXV_W-1:0] next_value_i,
  input logic [bsi_pkg::CNT_W-1:0]  member_count_i,
  input logic                      error_flag_i
);
  import bsi_pkg::*;

  logic             in_acc, out_acc;
  logic [1:0]       pend_q;
  logic             seen_err_q;
  logic [CNT_W-1:0] last_cnt_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= '0;
      seen_err_q <= 1'b0;
      last_cnt_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        seen_err_q <= seen_err_q || error_flag_i;
        last_cnt_q <= member_count_i;
      end
    end
  end

  // a result beat always belongs to an accepted operation
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result beat without an outstanding operation");

  // each operation moves the count by at most one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (member_count_i == last_cnt_q) ||
                (member_count_i == last_cnt_q + CNT_W'(1)) ||
                (member_count_i == last_cnt_q - CNT_W'(1)))
    else $error("member count jumped by more than one");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_err_q |-> error_flag_i)
    else $error("error flag dropped after being reported");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(ok_i) &&
      $stable(next_value_i) && $stable(member_count_i) && $stable(error_flag_i))
    else $error("stalled result beat changed");

endmodule

bind bitmap_set_with_iterator bsi_chk u_bsi_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (op_i.valid),
  .in_ready_i    (op_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .ok_i          (res_o.ok),
  .next_value_i  (res_o.next_value),
  .member_count_i(res_o.member_count),
  .error_flag_i  (res_o.error_flag)
);
